// ===== rtl/core/lz_token_stream_decompressor_macros.svh =====
// Assertion macros shared by the checker of the LZ token stream decompressor.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LZD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzd assertion failed");

`endif

// ===== rtl/core/lzd_pkg.sv =====
// Types and constants of the LZ token stream decompressor.
// No dependencies; the interfaces, the top level and the checker import it.
package lzd_pkg;

  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 16;
  localparam int CNT_W      = 3;
  localparam int TOKEN_TAIL = 3;

  localparam logic [BYTE_W-1:0] MARKER = 8'hFF;

  // Position inside a reference token.
  typedef enum logic [3:0] {
    PH_OPEN   = 4'b0001,
    PH_MARK   = 4'b0010,
    PH_OFF_LO = 4'b0100,
    PH_OFF_HI = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte0;
    logic [BYTE_W-1:0] out_byte1;
    logic [BYTE_W-1:0] out_byte2;
    logic [BYTE_W-1:0] out_byte3;
    logic [CNT_W-1:0]  byte_count;
    logic              bad_reference;
    logic              run_last;
    logic              stream_done;
  } out_word_t;

endpackage

// ===== rtl/core/lzd_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on lzd_pkg for the payload types.
interface lzd_in_if;
  import lzd_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lzd_out_if;
  import lzd_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lzd_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lz_token_stream_decompressor.sv =====
// Top level of the LZ token stream decompressor.
// Depends on lzd_pkg, the channel interfaces in lzd_if and the history RAM lzd_ram.
//
// The block takes one compressed byte per input word and returns result words of up
// to four decompressed bytes. A marker byte or an offset byte of a reference token is
// taken and gives no result. A literal passes through S_LIT before the next input word
// is accepted; a stream ending inside a token flushes its held bytes as literals. A
// reference passes through S_RD, then S_CPY; a bad reference or an empty end of
// stream passes through S_FLUSH. Produced bytes pass one at a time through the single
// write port of the history RAM, copied bytes also through its registered read port,
// which sets the copy rate of one byte per cycle; a result word waiting at the output
// stalls the engine only when the next word is ready to leave. The history RAM is not
// cleared after reset, since a valid reference never reaches an unwritten entry.
module lz_token_stream_decompressor #(
  parameter int WINDOW = 1024
) (
  input logic      clk,
  input logic      rst_n,
  lzd_in_if.sink   in_word,
  lzd_out_if.source out_word
);
  import lzd_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int EW = (CW > OFF_W) ? CW : OFF_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LIT   = 5'b00010,
    S_RD    = 5'b00100,
    S_CPY   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;
  phase_t                            phase_r, phase_nxt;
  logic [OFF_W-1:0]                  off_r, off_nxt;
  logic [AW-1:0]                     wp_r, wp_nxt;
  logic [CW-1:0]                     prod_r, prod_nxt;
  logic                              end_r, end_nxt;
  logic                              bad_r, bad_nxt;
  logic [1:0]                        pk_n_r, pk_n_nxt;
  logic [1:0]                        lit_n_r, lit_n_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              byp_hit_r, byp_hit_nxt;
  logic [TOKEN_TAIL-1:0][BYTE_W-1:0] lit_r, lit_nxt;
  logic [2:0][BYTE_W-1:0]            pk_r, pk_nxt;
  logic [BYTE_W-1:0]                 len_r, len_nxt;
  logic [AW-1:0]                     src_r, src_nxt;
  logic [BYTE_W-1:0]                 byp_data_r, byp_data_nxt;
  out_word_t                         out_r, out_nxt;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [BYTE_W-1:0]                 ram_wdata;
  logic [AW-1:0]                     ram_raddr;
  logic [BYTE_W-1:0]                 ram_rdata;

  logic [BYTE_W-1:0]                 in_byte;
  logic                              in_end;
  logic [BYTE_W-1:0]                 cur_byte;
  logic                              is_last;
  logic                              producing;
  logic                              need_emit;
  logic                              can_emit;
  logic                              go;
  logic [AW-1:0]                     wp_inc;
  logic [AW-1:0]                     src_inc;
  logic [CW-1:0]                     prod_inc;
  logic [EW-1:0]                     off_ext;
  logic [EW-1:0]                     wp_ext;
  logic [EW-1:0]                     src_full;
  logic                              ref_bad;
  out_word_t                         emit_word;

  lzd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW)
  ) u_lzd_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_byte = in_word.payload.data_byte;
  assign in_end  = in_word.payload.stream_end;

  assign in_word.ready    = (state_r == S_IDLE);
  assign out_word.valid   = out_valid_r;
  assign out_word.payload = out_r;

  assign wp_inc   = (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
  assign src_inc  = (src_r == AW'(WINDOW - 1)) ? '0 : src_r + AW'(1);
  assign prod_inc = (prod_r == CW'(WINDOW)) ? prod_r : prod_r + CW'(1);

  assign off_ext  = EW'(off_r);
  assign wp_ext   = EW'(wp_r);
  assign ref_bad  = (off_r == '0) || (off_ext > EW'(prod_r));
  assign src_full = (wp_ext >= off_ext) ? wp_ext - off_ext
                                        : wp_ext + EW'(WINDOW) - off_ext;

  always_comb begin
    if (state_r == S_CPY) begin
      cur_byte = byp_hit_r ? byp_data_r : ram_rdata;
      is_last  = (len_r == BYTE_W'(1));
    end else begin
      cur_byte = lit_r[0];
      is_last  = (lit_n_r == 2'd1);
    end
  end

  assign producing = (state_r == S_LIT) || (state_r == S_CPY);
  assign need_emit = is_last || (pk_n_r == 2'd3);
  assign can_emit  = !out_valid_r || out_word.ready;
  assign go        = producing && (!need_emit || can_emit);

  always_comb begin
    emit_word.out_byte0     = (pk_n_r > 2'd0) ? pk_r[0] :
                              (pk_n_r == 2'd0) ? cur_byte : '0;
    emit_word.out_byte1     = (pk_n_r > 2'd1) ? pk_r[1] :
                              (pk_n_r == 2'd1) ? cur_byte : '0;
    emit_word.out_byte2     = (pk_n_r > 2'd2) ? pk_r[2] :
                              (pk_n_r == 2'd2) ? cur_byte : '0;
    emit_word.out_byte3     = (pk_n_r == 2'd3) ? cur_byte : '0;
    emit_word.byte_count    = CNT_W'(pk_n_r) + CNT_W'(1);
    emit_word.bad_reference = 1'b0;
    emit_word.run_last      = is_last;
    emit_word.stream_done   = is_last && end_r;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    off_nxt       = off_r;
    wp_nxt        = wp_r;
    prod_nxt      = prod_r;
    end_nxt       = end_r;
    bad_nxt       = bad_r;
    pk_n_nxt      = pk_n_r;
    pk_nxt        = pk_r;
    lit_n_nxt     = lit_n_r;
    lit_nxt       = lit_r;
    len_nxt       = len_r;
    src_nxt       = src_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = cur_byte;
    ram_raddr     = src_r;

    if (out_valid_r && out_word.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Common path for every produced byte: history write, packing and emission.
    if (go) begin
      ram_we   = 1'b1;
      wp_nxt   = wp_inc;
      prod_nxt = prod_inc;
      if (need_emit) begin
        out_nxt       = emit_word;
        out_valid_nxt = 1'b1;
        pk_n_nxt      = 2'd0;
      end else begin
        pk_nxt[pk_n_r] = cur_byte;
        pk_n_nxt       = pk_n_r + 2'd1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_word.valid) begin
          end_nxt = in_end;
          bad_nxt = 1'b0;
          case (phase_r)
            PH_OPEN: begin
              if ((in_byte == MARKER) && !in_end) begin
                phase_nxt = PH_MARK;
              end else begin
                lit_nxt[0] = in_byte;
                lit_n_nxt  = 2'd1;
                state_nxt  = S_LIT;
              end
            end
            PH_MARK: begin
              if (in_end) begin
                lit_nxt[0] = MARKER;
                lit_nxt[1] = in_byte;
                lit_n_nxt  = 2'd2;
                state_nxt  = S_LIT;
                phase_nxt  = PH_OPEN;
                off_nxt    = '0;
              end else begin
                off_nxt   = {{(OFF_W - BYTE_W){1'b0}}, in_byte};
                phase_nxt = PH_OFF_LO;
              end
            end
            PH_OFF_LO: begin
              if (in_end) begin
                lit_nxt[0] = MARKER;
                lit_nxt[1] = off_r[BYTE_W-1:0];
                lit_nxt[2] = in_byte;
                lit_n_nxt  = 2'd3;
                state_nxt  = S_LIT;
                phase_nxt  = PH_OPEN;
                off_nxt    = '0;
              end else begin
                off_nxt[OFF_W-1:BYTE_W] = in_byte;
                phase_nxt               = PH_OFF_HI;
              end
            end
            PH_OFF_HI: begin
              phase_nxt = PH_OPEN;
              off_nxt   = '0;
              len_nxt   = in_byte;
              src_nxt   = src_full[AW-1:0];
              if (ref_bad) begin
                bad_nxt   = 1'b1;
                state_nxt = S_FLUSH;
              end else if (in_byte == '0) begin
                if (in_end) begin
                  state_nxt = S_FLUSH;
                end
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              phase_nxt = PH_OPEN;
            end
          endcase
        end
      end
      S_LIT: begin
        if (go) begin
          lit_nxt[0] = lit_r[1];
          lit_nxt[1] = lit_r[2];
          lit_n_nxt  = lit_n_r - 2'd1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CPY;
      end
      S_CPY: begin
        if (go) begin
          len_nxt   = len_r - BYTE_W'(1);
          src_nxt   = src_inc;
          ram_raddr = src_inc;
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          out_nxt               = '0;
          out_nxt.bad_reference = bad_r;
          out_nxt.run_last      = 1'b1;
          out_nxt.stream_done   = end_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The end of a stream returns the write side to a fresh start.
    if (end_r && ((go && is_last) || ((state_r == S_FLUSH) && can_emit))) begin
      wp_nxt   = '0;
      prod_nxt = '0;
    end
  end

  // A write to the address being read in the same cycle is forwarded.
  assign byp_hit_nxt  = ram_we && (ram_waddr == ram_raddr);
  assign byp_data_nxt = ram_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_OPEN;
      off_r       <= '0;
      wp_r        <= '0;
      prod_r      <= '0;
      end_r       <= 1'b0;
      bad_r       <= 1'b0;
      pk_n_r      <= '0;
      lit_n_r     <= '0;
      out_valid_r <= 1'b0;
      byp_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      off_r       <= off_nxt;
      wp_r        <= wp_nxt;
      prod_r      <= prod_nxt;
      end_r       <= end_nxt;
      bad_r       <= bad_nxt;
      pk_n_r      <= pk_n_nxt;
      lit_n_r     <= lit_n_nxt;
      out_valid_r <= out_valid_nxt;
      byp_hit_r   <= byp_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    pk_r       <= pk_nxt;
    len_r      <= len_nxt;
    src_r      <= src_nxt;
    byp_data_r <= byp_data_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== rtl/core/lzd_checker.sv =====
// Port-level checker of the LZ token stream decompressor and its bind statement.
// Depends on lzd_pkg and the assertion macros header.
`include "lz_token_stream_decompressor_macros.svh"

module lzd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lzd_pkg::out_word_t out_payload
);
  import lzd_pkg::*;

  // A stalled result word keeps its contents.
  `LZD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // A rise of the output valid only comes from work on an accepted word, never while idle.
  `LZD_ASSERT_SAME(a_out_from_work, $rose(out_valid), !$past(in_ready))

  // Only the last word of a run may be partly filled.
  `LZD_ASSERT_SAME(a_full_unless_last, out_valid && !out_payload.run_last,
    out_payload.byte_count == CNT_W'(4) && !out_payload.bad_reference)

  // A bad reference produces nothing and ends its run.
  `LZD_ASSERT_SAME(a_bad_empty, out_valid && out_payload.bad_reference,
    out_payload.byte_count == '0 && out_payload.run_last)

endmodule

bind lz_token_stream_decompressor lzd_checker u_lzd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_word.valid),
  .in_ready    (in_word.ready),
  .out_valid   (out_word.valid),
  .out_ready   (out_word.ready),
  .out_payload (out_word.payload)
);
